// ===== rtl/ostt_pkg.sv =====
// shared types, codes and sizes of the timer table
`timescale 1ns / 1ps
package ostt_pkg;
  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam logic [2:0] ACT_START_ONE = 3'd0;
  localparam logic [2:0] ACT_START_PER = 3'd1;
  localparam logic [2:0] ACT_RESTART   = 3'd2;
  localparam logic [2:0] ACT_CANCEL    = 3'd3;
  localparam logic [2:0] ACT_TICK      = 3'd4;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_CANCEL  = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_CTRL   = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;

  localparam logic [31:0] HALF = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]  op;
    logic        periodic;
    logic [7:0]  id;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [15:0] sig;
    logic [31:0] per;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [5:0]  slot_id;
    logic [7:0]  from_id;
    logic [7:0]  to_id;
    logic [15:0] sig;
    logic        periodic;
    logic        last;
    logic [6:0]  active_now;
    logic [6:0]  active_peak;
    logic [31:0] starts;
    logic [31:0] expiries;
  } res_t;
endpackage

// ===== rtl/ostt_front.sv =====
// request intake: decodes the action and queues commands for the engine
`timescale 1ns / 1ps
module ostt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [2:0]    in_tuser,
  input  logic [103:0]  in_tdata,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output ostt_pkg::cmd_t cmd
);
  import ostt_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       dec;
  logic       known;
  logic       push, pop;

  always_comb begin
    dec.op       = OP_TICK;
    dec.periodic = 1'b0;
    dec.id       = in_tdata[7:0];
    dec.src      = in_tdata[15:8];
    dec.dst      = in_tdata[23:16];
    dec.sig      = in_tdata[39:24];
    dec.per      = in_tdata[71:40];
    dec.now      = in_tdata[103:72];
    known        = 1'b1;
    case (in_tuser)
      ACT_START_ONE: dec.op = OP_START;
      ACT_START_PER: begin
        dec.op       = OP_START;
        dec.periodic = 1'b1;
      end
      ACT_RESTART:   dec.op = OP_RESTART;
      ACT_CANCEL:    dec.op = OP_CANCEL;
      ACT_TICK:      dec.op = OP_TICK;
      default:       known = 1'b0;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  // undefined actions are taken and dropped
  assign push      = in_tvalid && in_tready && known;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= dec;
  end
endmodule

// ===== rtl/ostt_div.sv =====
// bit-serial restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
module ostt_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic [31:0] rem
);
  logic [31:0] n_r, r_r, d_r;
  logic [5:0]  cnt_r;
  logic [32:0] t;
  logic        ge;

  assign t    = {r_r, n_r[31]};
  assign ge   = t >= {1'b0, d_r};
  assign busy = (cnt_r != 6'd0);
  assign rem  = r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'd0;
    end else if (start) begin
      cnt_r <= 6'd32;
    end else if (busy) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r <= num;
      r_r <= 32'd0;
      d_r <= den;
    end else if (busy) begin
      n_r <= {n_r[30:0], 1'b0};
      r_r <= ge ? 32'(t - {1'b0, d_r}) : t[31:0];
    end
  end
endmodule

// ===== rtl/ostt_engine.sv =====
// command engine: slot store, tick scan, catch-up and result register
`timescale 1ns / 1ps
module ostt_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  ostt_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output ostt_pkg::res_t out_res
);
  import ostt_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_REPLY = 3'd1;
  localparam logic [2:0] ST_COUNT = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]        st_r, st_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  due_r, due_nxt, free_r, free_nxt, rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, max_r, max_nxt;
  logic [31:0]       starts_r, starts_nxt, exps_r, exps_nxt;
  logic [SLOTS-1:0]  active_r, active_nxt, periodic_r, periodic_nxt;
  logic [7:0]        src_r [SLOTS];
  logic [7:0]        dst_r [SLOTS];
  logic [15:0]       sig_r [SLOTS];
  logic [31:0]       per_r [SLOTS];
  logic [31:0]       dl_r [SLOTS];
  res_t              out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              sw_fields, sw_per, sw_dl;
  logic [SLOT_W-1:0] sw_idx;
  logic [31:0]       sw_dl_val;

  logic [SLOT_W-1:0] rd_idx, found;
  logic              any_free, out_free, id_ok, cur_due, cur_rep;
  logic [31:0]       cur_dl, cur_per, d, q, x, kq, new_dl;
  logic              case_a;
  logic [CNT_W-1:0]  cnt_inc, tot_due, tot_free;
  logic              div_start, div_busy;
  logic [31:0]       div_num, div_den, div_rem;

  assign out_free = !out_valid_r || out_ready;
  assign rd_idx   = (st_r == ST_REPLY) ? cmd_r.id[SLOT_W-1:0] : idx_r;
  assign cur_dl   = dl_r[rd_idx];
  assign cur_per  = per_r[rd_idx];
  assign d        = cmd_r.now - cur_dl;
  assign cur_due  = active_r[rd_idx] && !d[31];
  assign cur_rep  = periodic_r[rd_idx] && (cur_per != 32'd0);
  assign id_ok    = (cmd_r.id < 8'(SLOTS)) && active_r[rd_idx];
  assign any_free = ~&active_r;
  assign cnt_inc  = cnt_r + CNT_W'(1);

  always_comb begin
    found = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) found = SLOT_W'(i);
    end
  end

  // catch-up: for p up to 2^31 new = now - (d mod p) + p,
  // otherwise step back by whole multiples of q = 2^32 - p
  assign case_a  = cur_per <= HALF;
  assign q       = 32'd0 - cur_per;
  assign x       = HALF - d;
  assign div_num = case_a ? d : x;
  assign div_den = case_a ? cur_per : q;
  assign kq      = x + ((div_rem == 32'd0) ? 32'd0 : q - div_rem);
  assign new_dl  = case_a ? cmd_r.now - div_rem + cur_per : cur_dl - kq;

  assign tot_due  = due_r + CNT_W'(cur_due);
  assign tot_free = free_r + CNT_W'(cur_due && !cur_rep);

  ostt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .rem   (div_rem)
  );

  assign cmd_ready = (st_r == ST_IDLE);

  always_comb begin
    st_nxt        = st_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    due_nxt       = due_r;
    free_nxt      = free_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    max_nxt       = max_r;
    starts_nxt    = starts_r;
    exps_nxt      = exps_r;
    active_nxt    = active_r;
    periodic_nxt  = periodic_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    sw_fields     = 1'b0;
    sw_per        = 1'b0;
    sw_dl         = 1'b0;
    sw_idx        = rd_idx;
    sw_dl_val     = cmd_r.now + cmd_r.per;
    div_start     = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt  = cmd;
          idx_nxt  = '0;
          due_nxt  = '0;
          free_nxt = '0;
          st_nxt   = (cmd.op == OP_TICK) ? ST_COUNT : ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.last  = 1'b1;
          case (cmd_r.op)
            OP_START: begin
              out_nxt.kind = KIND_START;
              if (cmd_r.per != 32'd0 && any_free) begin
                sw_fields           = 1'b1;
                sw_per              = 1'b1;
                sw_dl               = 1'b1;
                sw_idx              = found;
                active_nxt[found]   = 1'b1;
                periodic_nxt[found] = cmd_r.periodic;
                cnt_nxt             = cnt_inc;
                if (cnt_inc > max_r) max_nxt = cnt_inc;
                starts_nxt          = starts_r + 32'd1;
                out_nxt.ok          = 1'b1;
                out_nxt.slot_id     = 6'(found);
                out_nxt.periodic    = cmd_r.periodic;
              end
            end
            OP_RESTART: begin
              out_nxt.kind = KIND_CTRL;
              if (id_ok && cmd_r.per != 32'd0) begin
                sw_per          = 1'b1;
                sw_dl           = 1'b1;
                out_nxt.ok      = 1'b1;
                out_nxt.slot_id = 6'(rd_idx);
              end
            end
            default: begin
              out_nxt.kind = KIND_CTRL;
              if (id_ok) begin
                active_nxt[rd_idx] = 1'b0;
                cnt_nxt            = cnt_r - CNT_W'(1);
                out_nxt.ok         = 1'b1;
                out_nxt.slot_id    = 6'(rd_idx);
              end
            end
          endcase
          out_nxt.active_now  = 7'(cnt_nxt);
          out_nxt.active_peak = 7'(max_nxt);
          out_nxt.starts      = starts_nxt;
          out_nxt.expiries    = exps_r;
          st_nxt              = ST_IDLE;
        end
      end
      // first pass: count due slots so every result carries final totals
      ST_COUNT: begin
        due_nxt  = tot_due;
        free_nxt = tot_free;
        idx_nxt  = idx_r + SLOT_W'(1);
        if (idx_r == SLOT_W'(SLOTS - 1)) begin
          cnt_nxt  = cnt_r - tot_free;
          exps_nxt = exps_r + 32'(tot_due);
          rem_nxt  = tot_due;
          idx_nxt  = '0;
          st_nxt   = (tot_due == '0) ? ST_IDLE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cur_due) begin
          if (cur_rep) begin
            div_start = 1'b1;
            st_nxt    = ST_DIV;
          end else begin
            st_nxt = ST_EMIT;
          end
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          sw_dl     = 1'b1;
          sw_dl_val = new_dl;
          st_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.kind        = KIND_EXPIRY;
          out_nxt.ok          = 1'b1;
          out_nxt.slot_id     = 6'(idx_r);
          out_nxt.from_id     = src_r[idx_r];
          out_nxt.to_id       = dst_r[idx_r];
          out_nxt.sig         = sig_r[idx_r];
          out_nxt.periodic    = periodic_r[idx_r];
          out_nxt.last        = (rem_r == CNT_W'(1));
          out_nxt.active_now  = 7'(cnt_r);
          out_nxt.active_peak = 7'(max_r);
          out_nxt.starts      = starts_r;
          out_nxt.expiries    = exps_r;
          if (!cur_rep) active_nxt[idx_r] = 1'b0;
          rem_nxt = rem_r - CNT_W'(1);
          idx_nxt = idx_r + SLOT_W'(1);
          st_nxt  = (rem_r == CNT_W'(1)) ? ST_IDLE : ST_SCAN;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      max_r       <= '0;
      starts_r    <= 32'd0;
      exps_r      <= 32'd0;
      active_r    <= '0;
      periodic_r  <= '0;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      max_r       <= max_nxt;
      starts_r    <= starts_nxt;
      exps_r      <= exps_nxt;
      active_r    <= active_nxt;
      periodic_r  <= periodic_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    idx_r  <= idx_nxt;
    due_r  <= due_nxt;
    free_r <= free_nxt;
    out_r  <= out_nxt;
    if (sw_fields) begin
      src_r[sw_idx] <= cmd_r.src;
      dst_r[sw_idx] <= cmd_r.dst;
      sig_r[sw_idx] <= cmd_r.sig;
    end
    if (sw_per) per_r[sw_idx] <= cmd_r.per;
    if (sw_dl) dl_r[sw_idx] <= sw_dl_val;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> ($countones(active_r) == int'(cnt_r)))
    else $error("active count disagrees with active slots");
  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (max_r >= cnt_r) && (max_r <= CNT_W'(SLOTS)))
    else $error("peak below current count or above slot count");
  a_scan_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN || st_r == ST_EMIT || st_r == ST_DIV) |-> (rem_r != '0))
    else $error("expiry scan running with nothing left to report");
  a_div_held: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV && div_busy) |=> (st_r == ST_DIV))
    else $error("left catch-up before remainder was ready");
endmodule

// ===== rtl/one_shot_periodic_timer_table.sv =====
// top level of the one-shot / periodic timer table
`timescale 1ns / 1ps
// Requests enter on the in_ stream: tuser carries the action (start one-shot,
// start periodic, restart, cancel, tick), tdata the operands. Undefined
// actions are taken and produce nothing. Results leave on the out_ stream,
// tuser the result kind and tlast on the final result of a request.
// A two-entry request queue sits in front of the engine, so requests are
// taken while the engine works or the output waits.
// Start, restart and cancel present their one reply on out_tvalid after
// passing the request queue, the engine's command register and the result
// register. A tick passes the request queue into the engine, counts due
// slots in a first pass over all 16 slots, then scans the slots again,
// passing over those not due and emitting one expiry per due slot; for an
// expired periodic slot the catch-up deadline comes first from a bit-serial
// 32-step remainder unit.
// Reset clears all slots and counters at once; no clearing pass is needed.
// When out_tready is low the result register holds, the engine waits, and
// the request queue fills then drops in_tready.
module one_shot_periodic_timer_table (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [2:0]   in_tuser,   // action
  input  logic [103:0] in_tdata,   // slot, source, destination, signal, period, current_time
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,  // kind
  output logic         out_tlast,
  // ok, slot_id, from_id, to_id, signal_out, is_periodic, active_now, active_peak,
  // starts_total, expiries_total
  output logic [119:0] out_tdata
);
  import ostt_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;
  res_t res;

  ostt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  ostt_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tuser = res.kind;
  assign out_tlast = res.last;
  assign out_tdata = {2'b00, res.expiries, res.starts, res.active_peak, res.active_now,
                      res.periodic, res.sig, res.to_id, res.from_id, res.slot_id, res.ok};
endmodule
